// ----- hdl/fixed_point_float_alu_defines.svh -----
// assertion macros used by the checker file
`ifndef FIXED_POINT_FLOAT_ALU_DEFINES_SVH
`define FIXED_POINT_FLOAT_ALU_DEFINES_SVH

// clocked assertion, off while in reset
`define FPA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds across reset
`define FPA_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/fpa_pkg.sv -----
// types and codes of the fixed point float alu
package fpa_pkg;

  localparam logic [2:0] ACT_ADD = 3'd0;
  localparam logic [2:0] ACT_SUB = 3'd1;
  localparam logic [2:0] ACT_MUL = 3'd2;
  localparam logic [2:0] ACT_DIV = 3'd3;
  localparam logic [2:0] ACT_X2F = 3'd4;
  localparam logic [2:0] ACT_F2X = 3'd5;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
  } in_item_t;

  typedef struct packed {
    logic [63:0] result;
    logic        divide_by_zero;
    logic        conversion_clamped;
  } out_item_t;

  // what travels beside the divider state
  typedef struct packed {
    logic [2:0]  action;
    logic [63:0] res;
    logic        dz;
    logic        clamp;
    logic [31:0] divisor;
  } carry_t;

endpackage

// ----- hdl/fixed_point_float_alu.sv -----
// fixed point float alu: top level pipeline
// pipeline: stage 1 register, stage 2 register, divider chain, output register
// throughput: one item per cycle while the output is not stalled; the divider is one registered stage per quotient bit
// the whole pipe stalls together while a finished result waits at the output
// rst is synchronous active high and clears every stage valid bit; payload is not reset
module fixed_point_float_alu import fpa_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  // quotient width: dividend is a shifted left by FRAC_BITS
  localparam int DW = 32 + FRAC_BITS;

  // pipe moves when the output register is free or being taken
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // stage 1: float to fixed on both operands, leading one for fixed to float
  logic [31:0] a_fix, b_fix;
  logic        a_clamp, b_clamp;
  logic [4:0]  lead;

  fpa_to_fixed #(.FRAC_BITS(FRAC_BITS)) u_cvt_a (
    .bits(in_data.operand_a), .val(a_fix), .clamped(a_clamp)
  );
  fpa_to_fixed #(.FRAC_BITS(FRAC_BITS)) u_cvt_b (
    .bits(in_data.operand_b), .val(b_fix), .clamped(b_clamp)
  );

  // position of highest set bit of the raw fixed word
  always_comb begin
    lead = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (in_data.operand_a[i]) lead = 5'(i);
    end
  end

  logic        s1_valid;
  logic [2:0]  s1_op;
  logic [31:0] s1_a, s1_b, s1_x;
  logic        s1_ca, s1_cb;
  logic [4:0]  s1_p;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
    end
    if (adv) begin
      s1_op <= in_data.action;
      s1_a  <= a_fix;
      s1_b  <= b_fix;
      s1_ca <= a_clamp;
      s1_cb <= b_clamp;
      s1_x  <= in_data.operand_a;
      s1_p  <= lead;
    end
  end

  // stage 2: add, subtract, multiply, fixed to float rounding, float to fixed pass-through, divider setup
  logic [63:0] prod;
  logic [31:0] flt;
  logic [24:0] keep;
  logic [5:0]  pe;
  logic [4:0]  rsh;
  logic [31:0] rem_bits;
  logic [31:0] half;
  logic [7:0]  fexp;
  carry_t      c2;

  always_comb begin
    prod     = {32'd0, s1_a} * {32'd0, s1_b};
    pe       = {1'b0, s1_p};
    rsh      = s1_p - 5'd23;
    rem_bits = s1_x & ((32'd1 << rsh) - 32'd1);
    half     = 32'd1 << (rsh - 5'd1);
    keep     = 25'd0;
    if (s1_p <= 5'd23) begin
      keep = 25'(s1_x << (5'd23 - s1_p));
    end else begin
      keep = 25'(s1_x >> rsh);
      if (rem_bits > half || (rem_bits == half && keep[0])) begin
        keep = keep + 25'd1;
        if (keep[24]) begin
          keep = keep >> 1;
          pe   = pe + 6'd1;
        end
      end
    end
    // mantissa carry-out bumps the exponent
    fexp = 8'(pe) + 8'd127 - 8'(FRAC_BITS);
    flt  = (s1_x == 32'd0) ? 32'd0 : {1'b0, fexp, keep[22:0]};

    c2.action  = s1_op;
    c2.divisor = s1_b;
    c2.dz      = 1'b0;
    c2.clamp   = 1'b0;
    c2.res     = 64'd0;
    unique case (s1_op)
      ACT_ADD: begin
        c2.res   = {32'd0, s1_a + s1_b};
        c2.clamp = s1_ca | s1_cb;
      end
      ACT_SUB: begin
        c2.res   = {32'd0, s1_a - s1_b};
        c2.clamp = s1_ca | s1_cb;
      end
      ACT_MUL: begin
        c2.res   = prod >> FRAC_BITS;
        c2.clamp = s1_ca | s1_cb;
      end
      ACT_DIV: begin
        c2.dz    = (s1_b == 32'd0);
        c2.clamp = s1_ca | s1_cb;
      end
      ACT_X2F: c2.res = {32'd0, flt};
      ACT_F2X: begin
        c2.res   = {32'd0, s1_a};
        c2.clamp = s1_ca;
      end
      default: c2.res = 64'd0;
    endcase
  end

  // divider chain, index 0 is the stage 2 register
  logic          dv_valid [0:DW];
  carry_t        dv_carry [0:DW];
  logic [31:0]   dv_rem   [0:DW];
  logic [DW-1:0] dv_num   [0:DW];
  logic [DW-1:0] dv_q     [0:DW];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_valid[0] <= 1'b0;
    end else if (adv) begin
      dv_valid[0] <= s1_valid;
    end
    if (adv) begin
      dv_carry[0] <= c2;
      dv_rem[0]   <= 32'd0;
      dv_num[0]   <= {s1_a, {FRAC_BITS{1'b0}}};
      dv_q[0]     <= '0;
    end
  end

  for (genvar g = 0; g < DW; g++) begin : g_div
    fpa_div_stage #(.DW(DW)) u_stage (
      .clk    (clk),
      .rst    (rst),
      .en     (adv),
      .v_in   (dv_valid[g]),
      .c_in   (dv_carry[g]),
      .rem_in (dv_rem[g]),
      .num_in (dv_num[g]),
      .q_in   (dv_q[g]),
      .v_out  (dv_valid[g+1]),
      .c_out  (dv_carry[g+1]),
      .rem_out(dv_rem[g+1]),
      .num_out(dv_num[g+1]),
      .q_out  (dv_q[g+1])
    );
  end

  // output register: pick the quotient for divide items, or zero on divide by zero
  logic [63:0] fin_res;
  always_comb begin
    fin_res = dv_carry[DW].res;
    if (dv_carry[DW].action == ACT_DIV) begin
      fin_res = dv_carry[DW].dz ? 64'd0 : 64'(dv_q[DW]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv_valid[DW];
    end
    if (adv) begin
      out_data.result             <= fin_res;
      out_data.divide_by_zero     <= dv_carry[DW].dz;
      out_data.conversion_clamped <= dv_carry[DW].clamp;
    end
  end

endmodule

// ----- hdl/fpa_to_fixed.sv -----
// float32 to unsigned fixed point conversion with clamping
module fpa_to_fixed import fpa_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic [31:0] bits,
  output logic [31:0] val,
  output logic        clamped
);

  logic        sign;
  logic [7:0]  ex;
  logic [22:0] man;
  logic [23:0] m;
  logic [7:0]  ex_eff;
  logic [9:0]  ee;
  logic [9:0]  sh;
  logic [63:0] v;
  logic [31:0] mag;
  logic        big;
  logic        nan;

  always_comb begin
    sign   = bits[31];
    ex     = bits[30:23];
    man    = bits[22:0];
    m      = (ex == 8'd0) ? {1'b0, man} : {1'b1, man};
    ex_eff = (ex == 8'd0) ? 8'd1 : ex;
    ee     = 10'({2'b00, ex_eff}) - 10'd150 + 10'(FRAC_BITS);
    sh     = 10'd0 - ee;
    v      = {40'd0, m} << ee[4:0];
    nan    = 1'b0;
    big    = 1'b0;
    mag    = 32'd0;
    if (ex == 8'hFF) begin
      nan = (man != 23'd0);
      big = (man == 23'd0);
      mag = 32'hFFFF_FFFF;
    end else if (m == 24'd0) begin
      mag = 32'd0;
    end else if (!ee[9]) begin
      if (ee[8:5] != 4'd0 || v[63:32] != 32'd0) begin
        big = 1'b1;
        mag = 32'hFFFF_FFFF;
      end else begin
        mag = v[31:0];
      end
    end else begin
      mag = (sh[9:5] != 5'd0) ? 32'd0 : 32'({8'd0, m} >> sh[4:0]);
    end
    if (nan) begin
      val     = 32'd0;
      clamped = 1'b1;
    end else if (sign) begin
      val     = 32'd0;
      clamped = big || (mag != 32'd0);
    end else begin
      val     = mag;
      clamped = big;
    end
  end

endmodule

// ----- hdl/fpa_div_stage.sv -----
// one registered restoring divider step, one quotient bit
module fpa_div_stage import fpa_pkg::*; #(
  parameter int DW = 48
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          v_in,
  input  carry_t        c_in,
  input  logic [31:0]   rem_in,
  input  logic [DW-1:0] num_in,
  input  logic [DW-1:0] q_in,
  output logic          v_out,
  output carry_t        c_out,
  output logic [31:0]   rem_out,
  output logic [DW-1:0] num_out,
  output logic [DW-1:0] q_out
);

  logic [32:0] t;
  logic [32:0] diff;
  logic        ge;

  always_comb begin
    t    = {rem_in, num_in[DW-1]};
    ge   = (t >= {1'b0, c_in.divisor});
    diff = t - {1'b0, c_in.divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (en) begin
      v_out <= v_in;
    end
    if (en) begin
      c_out   <= c_in;
      rem_out <= ge ? diff[31:0] : t[31:0];
      num_out <= num_in << 1;
      q_out   <= {q_in[DW-2:0], ge};
    end
  end

endmodule

// ----- hdl/fpa_chk.sv -----
// port checker for the fixed point float alu, bound to the top level
`include "fixed_point_float_alu_defines.svh"

module fpa_chk import fpa_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  `FPA_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "output item changed while stalled")
  `FPA_ASSERT(a_ready_link, in_ready == (!out_valid || out_ready), "input ready does not follow output")
  `FPA_ASSERT(a_dz_zero, out_valid && out_data.divide_by_zero |-> out_data.result == 64'd0, "divide by zero with nonzero result")
  `FPA_ASSERT_RST(a_reset_empty, rst |=> !out_valid, "output valid after reset")

endmodule

bind fixed_point_float_alu fpa_chk u_fpa_chk (.*);
